[rtl/core/lec_pkg.sv]
// Shared types and constants for the 3x3 local extrema classifier.
// Luminance weights, rounding offset, class codes and the stage-enable bundle.
// No dependencies.
`default_nettype none

package lec_pkg;

    localparam int unsigned NB_COUNT = 8;
    localparam int unsigned PIX_W    = 32;

    // 0.16 luminance weights, summing to exactly 65536
    localparam logic [15:0] LUMA_WR = 16'd13933;
    localparam logic [15:0] LUMA_WG = 16'd46871;
    localparam logic [15:0] LUMA_WB = 16'd4732;

    // half of the 255*65536 denominator, for round-half-up
    localparam logic [31:0] INT_HALF = 32'd8355840;

    typedef enum logic [1:0] {
        CLS_NEITHER = 2'd0,
        CLS_MIN     = 2'd1,
        CLS_MAX     = 2'd2
    } t_class;

    // load enables for the register stages
    typedef struct packed {
        logic en_sum;
        logic en_prod;
        logic en_int;
        logic en_rank;
    } t_stage_en;

endpackage

`default_nettype wire

[rtl/core/lec_luma.sv]
// One intensity lane: weighted RGB sum, alpha product, divide by 255*65536.
// Three register stages driven by the stage enables; depends on lec_pkg.
`default_nettype none

module lec_luma (
    input  wire logic              i_clk,
    input  wire lec_pkg::t_stage_en i_en,
    input  wire logic [31:0]       i_pixel,
    output logic [7:0]             o_intensity
);
    import lec_pkg::*;

    logic [7:0]  w_r, w_g, w_b;
    logic [23:0] n_sum;
    logic [31:0] w_num;
    logic [15:0] w_div;

    logic [23:0] r_sum;
    logic [7:0]  r_alpha;
    logic [15:0] r_quo;
    logic [7:0]  r_int;

    assign w_r = i_pixel[7:0];
    assign w_g = i_pixel[15:8];
    assign w_b = i_pixel[23:16];

    // sum is at most 255*65536, so 24 bits are exact
    assign n_sum = {16'b0, w_r} * {8'b0, LUMA_WR}
                 + {16'b0, w_g} * {8'b0, LUMA_WG}
                 + {16'b0, w_b} * {8'b0, LUMA_WB};

    assign w_num = {24'b0, r_alpha} * {8'b0, r_sum} + INT_HALF;

    // r_quo stays below 65280, where (q + q/256 + 1)/256 equals q/255
    assign w_div = r_quo + {8'b0, r_quo[15:8]} + 16'd1;

    always_ff @(posedge i_clk) begin
        if (i_en.en_sum) begin
            r_sum   <= n_sum;
            r_alpha <= i_pixel[31:24];
        end
        if (i_en.en_prod) begin
            r_quo <= w_num[31:16];
        end
        if (i_en.en_int) begin
            r_int <= w_div[15:8];
        end
    end

    assign o_intensity = r_int;

endmodule

`default_nettype wire

[rtl/core/lec_rank.sv]
// Compares eight neighbor intensities against the center, counts and classifies.
// Output register stage of the pipeline; depends on lec_pkg.
`default_nettype none

module lec_rank (
    input  wire logic               i_clk,
    input  wire lec_pkg::t_stage_en i_en,
    input  wire logic [7:0]         i_center,
    input  wire logic [7:0]         i_nb [lec_pkg::NB_COUNT],
    output lec_pkg::t_class         o_class,
    output logic [7:0]              o_center,
    output logic [3:0]              o_ge,
    output logic [3:0]              o_le
);
    import lec_pkg::*;

    logic [3:0] n_ge, n_le;
    t_class     n_class;

    t_class     r_class;
    logic [7:0] r_center;
    logic [3:0] r_ge, r_le;

    always_comb begin
        n_ge = 4'd0;
        n_le = 4'd0;
        for (int k = 0; k < NB_COUNT; k++) begin
            n_ge = n_ge + {3'b0, (i_nb[k] >= i_center)};
            n_le = n_le + {3'b0, (i_nb[k] <= i_center)};
        end
        // minimum wins over maximum; equal counts, flat or not, give neither
        n_class = CLS_NEITHER;
        if (n_ge != n_le) begin
            if (n_ge == 4'(NB_COUNT)) begin
                n_class = CLS_MIN;
            end else if (n_le == 4'(NB_COUNT)) begin
                n_class = CLS_MAX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en_rank) begin
            r_class  <= n_class;
            r_center <= i_center;
            r_ge     <= n_ge;
            r_le     <= n_le;
        end
    end

    assign o_class  = r_class;
    assign o_center = r_center;
    assign o_ge     = r_ge;
    assign o_le     = r_le;

endmodule

`default_nettype wire

[rtl/core/local_extrema_classifier_3x3.sv]
// Classifies the center of a 3x3 RGBA8888 window as local minimum, local
// maximum or neither by 8-bit alpha-weighted luminance. One window is taken
// per clock while the output is not stalled; it passes through four register
// stages (weighted sum, alpha product, divide by 255*65536, compare and
// count), each holding its own valid bit, so a stall on the output backs up
// stage by stage and empty stages still fill. Nine intensity lanes
// run side by side, one per pixel. No configuration, no reset of data.
// Depends on lec_pkg, lec_luma, lec_rank.
`default_nettype none

module local_extrema_classifier_3x3 (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // center_pixel, nb_up_left, nb_up, nb_up_right, nb_left, nb_right,
    // nb_down_left, nb_down, nb_down_right; 32 bits each from bit 0 up
    input  wire logic [287:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // extremum_class[1:0], center_intensity[9:2], greater_equal_count[13:10],
    // less_equal_count[17:14], zero fill [23:18]
    output logic [23:0]       m_axis_tdata
);
    import lec_pkg::*;

    localparam int unsigned LANES = NB_COUNT + 1;

    logic       r_v_sum, r_v_prod, r_v_int, r_v_rank;
    logic       w_rdy_sum, w_rdy_prod, w_rdy_int, w_rdy_rank;
    t_stage_en  w_en;
    logic [7:0] w_int [LANES];
    logic [7:0] w_nb  [NB_COUNT];
    t_class     w_class;
    logic [7:0] w_center;
    logic [3:0] w_ge, w_le;

    // a stage takes new data when empty or when its successor takes its own
    assign w_rdy_rank = !r_v_rank || m_axis_tready;
    assign w_rdy_int  = !r_v_int  || w_rdy_rank;
    assign w_rdy_prod = !r_v_prod || w_rdy_int;
    assign w_rdy_sum  = !r_v_sum  || w_rdy_prod;

    assign w_en.en_sum  = w_rdy_sum;
    assign w_en.en_prod = w_rdy_prod;
    assign w_en.en_int  = w_rdy_int;
    assign w_en.en_rank = w_rdy_rank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_sum  <= 1'b0;
            r_v_prod <= 1'b0;
            r_v_int  <= 1'b0;
            r_v_rank <= 1'b0;
        end else begin
            if (w_rdy_sum)  r_v_sum  <= s_axis_tvalid;
            if (w_rdy_prod) r_v_prod <= r_v_sum;
            if (w_rdy_int)  r_v_int  <= r_v_prod;
            if (w_rdy_rank) r_v_rank <= r_v_int;
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        lec_luma u_luma (
            .i_clk       (i_clk),
            .i_en        (w_en),
            .i_pixel     (s_axis_tdata[g*PIX_W +: PIX_W]),
            .o_intensity (w_int[g])
        );
    end

    for (genvar g = 0; g < NB_COUNT; g++) begin : g_nb
        assign w_nb[g] = w_int[g+1];
    end

    lec_rank u_rank (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_center (w_int[0]),
        .i_nb     (w_nb),
        .o_class  (w_class),
        .o_center (w_center),
        .o_ge     (w_ge),
        .o_le     (w_le)
    );

    assign s_axis_tready = w_rdy_sum;
    assign m_axis_tvalid = r_v_rank;
    assign m_axis_tdata  = {6'b0, w_le, w_ge, w_center, w_class};

endmodule

`default_nettype wire

[rtl/core/lec_checker.sv]
// Port-level checks for local_extrema_classifier_3x3, attached by bind.
// Depends on lec_pkg for the class codes.
`default_nettype none

module lec_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [23:0]  m_axis_tdata
);
    import lec_pkg::*;

    logic [1:0] w_cls;
    logic [3:0] w_ge, w_le;

    assign w_cls = m_axis_tdata[1:0];
    assign w_ge  = m_axis_tdata[13:10];
    assign w_le  = m_axis_tdata[17:14];

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed or dropped");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // an open output lets the whole pipeline advance
    a_no_bubble_stall: assert property (@(posedge i_clk)
        m_axis_tready |-> s_axis_tready)
        else $error("input blocked while output is open");

    // every neighbor falls into at least one count, and a class agrees with them
    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ({1'b0, w_ge} + {1'b0, w_le} >= 5'd8)
                          && w_ge <= 4'd8 && w_le <= 4'd8)
        else $error("neighbor counts inconsistent");

    a_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_cls == CLS_NEITHER)
                       || (w_cls == CLS_MIN && w_ge == 4'd8 && w_le != 4'd8)
                       || (w_cls == CLS_MAX && w_le == 4'd8 && w_ge != 4'd8))
        else $error("class does not match counts");

endmodule

bind local_extrema_classifier_3x3 lec_checker u_lec_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[verif/local_extrema_classifier_3x3_tb.sv]
// Self-checking testbench for local_extrema_classifier_3x3: random and directed 3x3
// windows go in, and each result is checked against a built-in luminance classifier.
// Depends on lec_pkg and the local_extrema_classifier_3x3 RTL.
`timescale 1ns / 100ps

module local_extrema_classifier_3x3_tb;

    import lec_pkg::*;

    localparam int LIMIT_CYCLES    = 400000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int WINDOWS_PER_RUN = 367;

    typedef struct packed {
        t_class     cls;
        logic [7:0] luma;
        logic [3:0] ge;
        logic [3:0] le;
    } t_window_result;

    logic         i_clk;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // center_pixel, nb_up_left, nb_up, nb_up_right, nb_left, nb_right,
    // nb_down_left, nb_down, nb_down_right; 32 bits each from bit 0 up
    logic [287:0] s_axis_tdata  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // extremum_class[1:0], center_intensity[9:2], greater_equal_count[13:10],
    // less_equal_count[17:14], zero fill [23:18]
    logic [23:0]  m_axis_tdata;

    logic [287:0]   pending_windows[$];
    t_window_result predicted_results[$];

    int tx_idle_pct = 13;
    int rx_idle_pct = 46;
    int mismatches  = 0;
    int windows_in  = 0;
    int results_out = 0;
    int minima_seen = 0;
    int maxima_seen = 0;
    int cycle_count = 0;

    local_extrema_classifier_3x3 i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // alpha-weighted luminance, rounded half up, 0..255
    function automatic logic [7:0] pixel_luma(input logic [31:0] px);
        longint unsigned r, g, b, a, s, v;
        r = px[7:0];
        g = px[15:8];
        b = px[23:16];
        a = px[31:24];
        s = 64'(LUMA_WR) * r + 64'(LUMA_WG) * g + 64'(LUMA_WB) * b;
        v = (a * s + 64'(INT_HALF)) / (64'd255 * 64'd65536);
        return v[7:0];
    endfunction

    function automatic t_window_result classify_window(input logic [287:0] win);
        t_window_result res;
        logic [7:0]     ctr;
        logic [7:0]     nbl;
        int             ge;
        int             le;
        ctr = pixel_luma(win[31:0]);
        ge  = 0;
        le  = 0;
        for (int k = 1; k <= 8; k++) begin
            nbl = pixel_luma(win[32*k +: 32]);
            if (nbl >= ctr) ge++;
            if (nbl <= ctr) le++;
        end
        res.cls = CLS_NEITHER;
        // equal counts (flat window included) stay neither; minimum wins over maximum
        if (ge != le) begin
            if (ge == 8)
                res.cls = CLS_MIN;
            else if (le == 8)
                res.cls = CLS_MAX;
        end
        res.luma = ctr;
        res.ge   = 4'(ge);
        res.le   = 4'(le);
        return res;
    endfunction

    function automatic logic [31:0] rand_pixel();
        logic [31:0] p;
        p = $urandom;
        case ($urandom_range(7))
            0: p[31:24] = 8'h00;
            1: p[31:24] = 8'hFF;
            default: ;
        endcase
        return p;
    endfunction

    // mix of plain random windows, forced minima or maxima, and few-color windows with ties
    function automatic logic [287:0] rand_window();
        logic [287:0] w;
        logic [31:0]  palette[3];
        logic [31:0]  tmp;
        logic [7:0]   best;
        logic [7:0]   cur;
        int           mode;
        int           pick;
        mode = $urandom_range(3);
        for (int k = 0; k < 9; k++) w[32*k +: 32] = rand_pixel();
        if (mode == 3) begin
            for (int k = 0; k < 3; k++) palette[k] = rand_pixel();
            for (int k = 0; k < 9; k++) w[32*k +: 32] = palette[$urandom_range(2)];
        end else if (mode != 0) begin
            pick = 0;
            best = pixel_luma(w[31:0]);
            for (int k = 1; k < 9; k++) begin
                cur = pixel_luma(w[32*k +: 32]);
                if ((mode == 1 && cur < best) || (mode == 2 && cur > best)) begin
                    best = cur;
                    pick = k;
                end
            end
            // move the darkest or brightest pixel to the center
            tmp               = w[31:0];
            w[31:0]           = w[32*pick +: 32];
            w[32*pick +: 32]  = tmp;
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_result(input logic [23:0] got);
        t_window_result want;
        if (predicted_results.size() == 0) begin
            report_mismatch($sformatf("result 0x%06h with nothing outstanding", got));
        end else begin
            want = predicted_results.pop_front();
            if (got[1:0] !== want.cls)
                report_mismatch($sformatf("class %0d, want %0d", got[1:0], want.cls));
            if (got[9:2] !== want.luma)
                report_mismatch($sformatf("intensity %0d, want %0d", got[9:2], want.luma));
            if (got[13:10] !== want.ge)
                report_mismatch($sformatf("ge count %0d, want %0d", got[13:10], want.ge));
            if (got[17:14] !== want.le)
                report_mismatch($sformatf("le count %0d, want %0d", got[17:14], want.le));
            if (want.cls == CLS_MIN) minima_seen++;
            if (want.cls == CLS_MAX) maxima_seen++;
        end
        results_out++;
    endtask

    // driver: predict on each input transfer, then load the next window or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predicted_results.push_back(classify_window(s_axis_tdata));
                windows_in++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_windows.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    s_axis_tdata  <= pending_windows.pop_front();
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: random backpressure, check each output transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL");
            $finish;
        end
    end

    // hold off until every window is through and every result is back
    task automatic wait_drained();
        while (pending_windows.size() != 0 || s_axis_tvalid || predicted_results.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // flat windows: black, white, and transparent pixels of different colors
        pending_windows.push_back({9{32'h0000_0000}});
        pending_windows.push_back({9{32'hFFFF_FFFF}});
        pending_windows.push_back({{8{32'h00FF_FFFF}}, 32'h0012_3456});
        // clear minimum and maximum
        pending_windows.push_back({{8{32'hFFFF_FFFF}}, 32'hFF00_0000});
        pending_windows.push_back({{8{32'hFF00_0000}}, 32'hFFFF_FFFF});
        // extrema with one tied neighbor
        pending_windows.push_back({{7{32'hFFFF_FFFF}}, 32'hFF00_0000, 32'hFF00_0000});
        pending_windows.push_back({{7{32'hFF00_0000}}, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
        // equal counts without a flat window, and near misses
        pending_windows.push_back({{4{32'hFFFF_FFFF}}, {4{32'hFF00_0000}}, 32'hFF80_8080});
        pending_windows.push_back({{5{32'hFFFF_FFFF}}, {3{32'hFF00_0000}}, 32'hFF80_8080});
        pending_windows.push_back({{7{32'hFFFF_FFFF}}, 32'hFF00_0000, 32'hFF80_8080});
        pending_windows.push_back({32'hFFFF_FFFF, {7{32'hFF00_0000}}, 32'hFF80_8080});
        // single color channels at full scale
        pending_windows.push_back({{8{32'hFF00_FF00}}, 32'hFF00_00FF});
        pending_windows.push_back({{8{32'hFF00_00FF}}, 32'hFFFF_0000});
        pending_windows.push_back({{8{32'hFFFF_0000}}, 32'hFF00_FF00});
        // alpha one step apart
        pending_windows.push_back({{8{32'h7FFF_FFFF}}, 32'h80FF_FFFF});
        pending_windows.push_back({{8{32'h80FF_FFFF}}, 32'h7FFF_FFFF});
        // alternating bit patterns and small values near the rounding point
        pending_windows.push_back({{4{32'hAAAA_AAAA, 32'h5555_5555}}, 32'hAAAA_AAAA});
        pending_windows.push_back({{4{32'h5555_5555, 32'hAAAA_AAAA}}, 32'h5555_5555});
        pending_windows.push_back({{8{32'h0101_0101}}, 32'h0202_0202});
        pending_windows.push_back({{8{32'h03FF_FFFF}}, 32'h0101_0101});

        for (int run = 0; run < 3; run++) begin
            case (run)
                0: begin tx_idle_pct = 13; rx_idle_pct = 46; end
                1: begin tx_idle_pct = 46; rx_idle_pct = 13; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            for (int n = 0; n < WINDOWS_PER_RUN; n++) pending_windows.push_back(rand_window());
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d windows (%0d minima, %0d maxima) over three stall patterns",
                 windows_in, minima_seen, maxima_seen);
        $display("%0d results checked, %0d mismatches", results_out, mismatches);
        if (mismatches == 0 && predicted_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[local_extrema_classifier_3x3.f]
rtl/core/lec_pkg.sv
rtl/core/lec_luma.sv
rtl/core/lec_rank.sv
rtl/core/local_extrema_classifier_3x3.sv
rtl/core/lec_checker.sv
verif/local_extrema_classifier_3x3_tb.sv
